FILE: rtl/sc2km_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sc2km_pkg;

    localparam int ROWS       = 8;
    localparam int COLS       = 5;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_FRAMES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_FRAMES = 2'd2;

    localparam logic [CFG_W-1:0] HOLD_FRAMES_RST   = 4'd3;
    localparam logic [CFG_W-1:0] GAP_FRAMES_RST    = 4'd2;
    localparam logic [CFG_W-1:0] ESCAPE_FRAMES_RST = 4'd5;

    // command codes
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_DUMP    = 3'd1;
    localparam logic [2:0] CMD_LAUNCH  = 3'd2;
    localparam logic [2:0] CMD_LOAD    = 3'd3;
    localparam logic [2:0] CMD_OVERLAY = 3'd4;

    // special bytes
    localparam logic [7:0] CHAR_EOT     = 8'h04;
    localparam logic [7:0] CHAR_DC2     = 8'h12;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_SI      = 8'h0F;
    localparam logic [7:0] CHAR_ESC     = 8'h1B;
    localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
    localparam logic [7:0] CHAR_UPPER_O = 8'h4F;
    localparam logic [7:0] CHAR_UPPER_P = 8'h50;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_D = 8'h44;
    localparam logic [7:0] READ_IDLE    = 8'hFF;

    typedef struct packed {
        logic [CFG_W-1:0] hold_frames;
        logic [CFG_W-1:0] gap_frames;
        logic [CFG_W-1:0] escape_timeout_frames;
    } cfg_t;

    typedef struct packed {
        logic       operation;
        logic       char_valid;
        logic [7:0] char_code;
        logic       follow_valid;
        logic [7:0] follow_code;
        logic [7:0] row_select;
    } item_t;

    typedef struct packed {
        logic [2:0] command;
        logic       took_follow;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic       shift;
        logic [2:0] row;
        logic [2:0] col;
    } key_entry_t;

    function automatic key_entry_t plain_key(input logic [2:0] r, input logic [2:0] c);
        key_entry_t e;
        e.valid = 1'b1;
        e.shift = 1'b0;
        e.row   = r;
        e.col   = c;
        return e;
    endfunction

    function automatic key_entry_t shift_key(input logic [2:0] r, input logic [2:0] c);
        key_entry_t e;
        e.valid = 1'b1;
        e.shift = 1'b1;
        e.row   = r;
        e.col   = c;
        return e;
    endfunction

    // ASCII to matrix position
    function automatic key_entry_t char_key(input logic [6:0] code);
        key_entry_t e;
        e = '0;
        case (code)
            7'h0D, 7'h0A: e = plain_key(3'd6, 3'd0);
            7'h08, 7'h7F: e = shift_key(3'd4, 3'd0);
            7'h20: e = plain_key(3'd7, 3'd0);
            7'h30: e = plain_key(3'd4, 3'd0);
            7'h31: e = plain_key(3'd3, 3'd0);
            7'h32: e = plain_key(3'd3, 3'd1);
            7'h33: e = plain_key(3'd3, 3'd2);
            7'h34: e = plain_key(3'd3, 3'd3);
            7'h35: e = plain_key(3'd3, 3'd4);
            7'h36: e = plain_key(3'd4, 3'd4);
            7'h37: e = plain_key(3'd4, 3'd3);
            7'h38: e = plain_key(3'd4, 3'd2);
            7'h39: e = plain_key(3'd4, 3'd1);
            7'h61: e = plain_key(3'd1, 3'd0);
            7'h62: e = plain_key(3'd7, 3'd4);
            7'h63: e = plain_key(3'd0, 3'd3);
            7'h64: e = plain_key(3'd1, 3'd2);
            7'h65: e = plain_key(3'd2, 3'd2);
            7'h66: e = plain_key(3'd1, 3'd3);
            7'h67: e = plain_key(3'd1, 3'd4);
            7'h68: e = plain_key(3'd6, 3'd4);
            7'h69: e = plain_key(3'd5, 3'd2);
            7'h6A: e = plain_key(3'd6, 3'd3);
            7'h6B: e = plain_key(3'd6, 3'd2);
            7'h6C: e = plain_key(3'd6, 3'd1);
            7'h6D: e = plain_key(3'd7, 3'd2);
            7'h6E: e = plain_key(3'd7, 3'd3);
            7'h6F: e = plain_key(3'd5, 3'd1);
            7'h70: e = plain_key(3'd5, 3'd0);
            7'h71: e = plain_key(3'd2, 3'd0);
            7'h72: e = plain_key(3'd2, 3'd3);
            7'h73: e = plain_key(3'd1, 3'd1);
            7'h74: e = plain_key(3'd2, 3'd4);
            7'h75: e = plain_key(3'd5, 3'd3);
            7'h76: e = plain_key(3'd0, 3'd4);
            7'h77: e = plain_key(3'd2, 3'd1);
            7'h78: e = plain_key(3'd0, 3'd2);
            7'h79: e = plain_key(3'd5, 3'd4);
            7'h7A: e = plain_key(3'd0, 3'd1);
            7'h41: e = shift_key(3'd1, 3'd0);
            7'h42: e = shift_key(3'd7, 3'd4);
            7'h43: e = shift_key(3'd0, 3'd3);
            7'h44: e = shift_key(3'd1, 3'd2);
            7'h45: e = shift_key(3'd2, 3'd2);
            7'h46: e = shift_key(3'd1, 3'd3);
            7'h47: e = shift_key(3'd1, 3'd4);
            7'h48: e = shift_key(3'd6, 3'd4);
            7'h49: e = shift_key(3'd5, 3'd2);
            7'h4A: e = shift_key(3'd6, 3'd3);
            7'h4B: e = shift_key(3'd6, 3'd2);
            7'h4C: e = shift_key(3'd6, 3'd1);
            7'h4D: e = shift_key(3'd7, 3'd2);
            7'h4E: e = shift_key(3'd7, 3'd3);
            7'h4F: e = shift_key(3'd5, 3'd1);
            7'h50: e = shift_key(3'd5, 3'd0);
            7'h51: e = shift_key(3'd2, 3'd0);
            7'h52: e = shift_key(3'd2, 3'd3);
            7'h53: e = shift_key(3'd1, 3'd1);
            7'h54: e = shift_key(3'd2, 3'd4);
            7'h55: e = shift_key(3'd5, 3'd3);
            7'h56: e = shift_key(3'd0, 3'd4);
            7'h57: e = shift_key(3'd2, 3'd1);
            7'h58: e = shift_key(3'd0, 3'd2);
            7'h59: e = shift_key(3'd5, 3'd4);
            7'h5A: e = shift_key(3'd0, 3'd1);
            7'h21: e = shift_key(3'd3, 3'd0);
            7'h40: e = shift_key(3'd3, 3'd1);
            7'h23: e = shift_key(3'd3, 3'd2);
            7'h24: e = shift_key(3'd3, 3'd3);
            7'h25: e = shift_key(3'd3, 3'd4);
            7'h5E: e = shift_key(3'd4, 3'd4);
            7'h26: e = shift_key(3'd4, 3'd3);
            7'h22: e = shift_key(3'd5, 3'd0);
            7'h2E: e = plain_key(3'd7, 3'd1);
            7'h2C: e = shift_key(3'd7, 3'd1);
            7'h2D: e = shift_key(3'd6, 3'd3);
            7'h2B: e = shift_key(3'd6, 3'd2);
            7'h3D: e = shift_key(3'd6, 3'd1);
            7'h3B: e = shift_key(3'd0, 3'd2);
            7'h3A: e = shift_key(3'd0, 3'd1);
            7'h2F: e = shift_key(3'd0, 3'd4);
            7'h3C: e = shift_key(3'd2, 3'd3);
            7'h3E: e = shift_key(3'd2, 3'd4);
            7'h28: e = shift_key(3'd4, 3'd1);
            7'h29: e = shift_key(3'd4, 3'd0);
            7'h2A: e = shift_key(3'd7, 3'd2);
            default: e = '0;
        endcase
        return e;
    endfunction

    // CSI finals: A up, B down, C right, D left
    function automatic key_entry_t cursor_key(input logic [1:0] sel);
        key_entry_t e;
        e = '0;
        case (sel)
            2'd0: e = shift_key(3'd4, 3'd3);
            2'd1: e = shift_key(3'd4, 3'd4);
            2'd2: e = shift_key(3'd4, 3'd2);
            2'd3: e = shift_key(3'd3, 3'd4);
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sc2km_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module sc2km_engine (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     step,
    input  sc2km_pkg::item_t        item,
    input  sc2km_pkg::cfg_t         cfg,
    output sc2km_pkg::result_t      result
);
    import sc2km_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_CSI  = 3'd2,
        MODE_HOLD = 3'd3,
        MODE_GAP  = 3'd4
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [CFG_W-1:0]   hgc_reg, hgc_next;
    logic [CFG_W-1:0]   esc_reg, esc_next;
    logic [COLS-1:0]    matrix_reg [ROWS];
    logic [COLS-1:0]    matrix_next [ROWS];

    logic [CFG_W-1:0]   hgc_dec, esc_dec;
    logic               hgc_done, esc_done;
    logic               do_press, do_clear;
    key_entry_t         press_entry, rom_entry;
    logic [COLS-1:0]    pressed;
    logic [7:0]         ch;
    logic [1:0]         cursor_sel;

    assign ch         = item.char_code;
    assign hgc_done   = (hgc_reg <= CFG_W'(1));
    assign esc_done   = (esc_reg <= CFG_W'(1));
    assign hgc_dec    = (hgc_reg == '0) ? '0 : hgc_reg - CFG_W'(1);
    assign esc_dec    = (esc_reg == '0) ? '0 : esc_reg - CFG_W'(1);
    assign rom_entry  = char_key(ch[6:0]);
    assign cursor_sel = 2'(ch - CHAR_UPPER_A);

    always_comb
    begin
        pressed = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (!item.row_select[r])
                pressed = pressed | matrix_reg[r];
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        hgc_next    = hgc_reg;
        esc_next    = esc_reg;
        matrix_next = matrix_reg;
        do_press    = 1'b0;
        do_clear    = 1'b0;
        press_entry = rom_entry;
        result.command     = CMD_NONE;
        result.took_follow = 1'b0;
        result.read_data   = READ_IDLE;

        if (item.operation)
        begin
            result.read_data = {3'b111, ~pressed};
        end
        else
        begin
            case (mode_reg)
                MODE_ESC:
                begin
                    if (item.char_valid && ch == CHAR_LBRACK)
                    begin
                        mode_next = MODE_CSI;
                        esc_next  = cfg.escape_timeout_frames;
                    end
                    else if (item.char_valid && ch == CHAR_UPPER_O)
                    begin
                        result.took_follow = item.follow_valid;
                        if (item.follow_valid && item.follow_code == CHAR_UPPER_P)
                            result.command = CMD_OVERLAY;
                        mode_next = MODE_IDLE;
                    end
                    else if (item.char_valid)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        esc_next = esc_dec;
                        if (esc_done)
                            mode_next = MODE_IDLE;
                    end
                end
                MODE_CSI:
                begin
                    if (!item.char_valid)
                    begin
                        esc_next = esc_dec;
                        if (esc_done)
                            mode_next = MODE_IDLE;
                    end
                    else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_D]})
                    begin
                        do_press    = 1'b1;
                        press_entry = cursor_key(cursor_sel);
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_HOLD:
                begin
                    hgc_next = hgc_dec;
                    if (hgc_done)
                    begin
                        do_clear  = 1'b1;
                        hgc_next  = cfg.gap_frames;
                        mode_next = MODE_GAP;
                    end
                end
                MODE_GAP:
                begin
                    hgc_next = hgc_dec;
                    if (hgc_done)
                        mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (item.char_valid && !ch[7])
                    begin
                        if (ch == CHAR_EOT)
                            result.command = CMD_DUMP;
                        else if (ch == CHAR_DC2)
                            result.command = CMD_LAUNCH;
                        else if (ch == CHAR_FF)
                            result.command = CMD_LOAD;
                        else if (ch == CHAR_SI)
                            result.command = CMD_OVERLAY;
                        else if (ch == CHAR_ESC)
                        begin
                            mode_next = MODE_ESC;
                            esc_next  = cfg.escape_timeout_frames;
                        end
                        else if (rom_entry.valid)
                            do_press = 1'b1;
                    end
                end
            endcase

            if (do_clear || do_press)
            begin
                for (int r = 0; r < ROWS; r++)
                    matrix_next[r] = '0;
            end
            if (do_press)
            begin
                matrix_next[press_entry.row] = COLS'(5'b00001 << press_entry.col);
                if (press_entry.shift)
                    matrix_next[0] = matrix_next[0] | COLS'(1);
                hgc_next  = cfg.hold_frames;
                mode_next = MODE_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            hgc_reg  <= '0;
            esc_reg  <= '0;
            for (int r = 0; r < ROWS; r++)
                matrix_reg[r] <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            hgc_reg    <= hgc_next;
            esc_reg    <= esc_next;
            matrix_reg <= matrix_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/serial_char_to_key_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

// Turns serial characters into presses on an 8x5 key matrix and answers
// keyboard port reads from that matrix. Each item is a frame tick (tuser 0),
// optionally carrying a character, or a port read (tuser 1). The item is
// captured in an input register, decoded combinationally and applied to the
// matrix state as its result moves into a result register, where it is held
// until taken; the engine steps only when the result register can advance.
// Items are accepted at one item per clock as long as the result side keeps
// up. Hold, gap and escape timeouts count frame ticks, not clocks.
module serial_char_to_key_matrix (
    input  wire                             clk,
    input  wire                             rst_n,
    // slave item stream
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // char_valid, char_code[7:0], follow_valid, follow_code[7:0], row_select[7:0]
    input  wire  [31:0]                     s_tdata,
    // operation
    input  wire                             s_tuser,
    // master result stream
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // command[2:0], took_follow, read_data[7:0]
    output logic [15:0]                     m_tdata,
    // configuration writes
    input  wire                             cfg_we,
    input  wire  [sc2km_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [sc2km_pkg::CFG_W-1:0]     cfg_data
);
    import sc2km_pkg::*;

    cfg_t       cfg_reg;
    item_t      in_item;
    item_t      in_reg;
    logic       in_valid_reg;
    result_t    out_reg;
    result_t    engine_result;
    logic       out_valid_reg;
    logic       advance;
    logic       step;

    assign in_item.operation    = s_tuser;
    assign in_item.char_valid   = s_tdata[0];
    assign in_item.char_code    = s_tdata[8:1];
    assign in_item.follow_valid = s_tdata[9];
    assign in_item.follow_code  = s_tdata[17:10];
    assign in_item.row_select   = s_tdata[25:18];

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.read_data, out_reg.took_follow, out_reg.command};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_frames           <= HOLD_FRAMES_RST;
            cfg_reg.gap_frames            <= GAP_FRAMES_RST;
            cfg_reg.escape_timeout_frames <= ESCAPE_FRAMES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_FRAMES:   cfg_reg.hold_frames           <= cfg_data;
                REG_GAP_FRAMES:    cfg_reg.gap_frames            <= cfg_data;
                REG_ESCAPE_FRAMES: cfg_reg.escape_timeout_frames <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_reg <= in_item;
        if (step)
            out_reg <= engine_result;
    end

    sc2km_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_reg),
        .cfg    (cfg_reg),
        .result (engine_result)
    );

    // the follow byte is only consumed after ESC O, which gives overlay or nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> (m_tdata[2:0] == CMD_NONE || m_tdata[2:0] == CMD_OVERLAY))
        else $error("took_follow with unexpected command");

    // input side only stalls when both stages are full and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without back-pressure");

    // a port read never produces a command
    assert property (@(posedge clk) disable iff (!rst_n)
        step && in_reg.operation |=> out_reg.command == CMD_NONE && !out_reg.took_follow)
        else $error("port read produced a command");

endmodule

`default_nettype wire

FILE: dv/serial_char_to_key_matrix_test.sv
`timescale 1ns / 1ps

module serial_char_to_key_matrix_test;

    import sc2km_pkg::*;

    localparam int LIMIT_CYCLES   = 500000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS    = 90;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [2:0] {KB_IDLE, KB_ESC, KB_CSI, KB_HOLD, KB_GAP} kb_mode_t;

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [15:0] m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // translator state as seen from outside
    logic [4:0] kmat [8];
    kb_mode_t   kb_mode;
    logic [3:0] hold_gap_left;
    logic [3:0] esc_left;
    logic [3:0] hold_cfg;
    logic [3:0] gap_cfg;
    logic [3:0] esc_cfg;
    logic [7:0] key_map [128];   // valid, shift, row[2:0], col[2:0]
    logic [7:0] cursor_map [4];

    result_t  expected_results [$];
    dir_row_t dir_tab [$];
    int       mismatch_count = 0;
    int       burst_left = 8;
    int       holdoff_req = 0;
    int       holdoff_seen = 0;
    int       stall_left = 0;
    int       seg_left = 0;
    int       stall_density = 0;
    int       cycle_cnt = 0;

    serial_char_to_key_matrix uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void set_key(input logic [7:0] ch, input logic shift,
                                    input logic [5:0] pos);
        key_map[ch[6:0]] = {1'b1, shift, pos};
    endfunction

    // lower case plain, upper case same key with shift
    function automatic void set_letter(input logic [7:0] ch, input logic [5:0] pos);
        set_key(ch, 1'b0, pos);
        set_key(ch - 8'd32, 1'b1, pos);
    endfunction

    function automatic void build_key_maps();
        for (int i = 0; i < 128; i++)
            key_map[i] = '0;
        set_letter("a", 6'o10); set_letter("b", 6'o74); set_letter("c", 6'o03);
        set_letter("d", 6'o12); set_letter("e", 6'o22); set_letter("f", 6'o13);
        set_letter("g", 6'o14); set_letter("h", 6'o64); set_letter("i", 6'o52);
        set_letter("j", 6'o63); set_letter("k", 6'o62); set_letter("l", 6'o61);
        set_letter("m", 6'o72); set_letter("n", 6'o73); set_letter("o", 6'o51);
        set_letter("p", 6'o50); set_letter("q", 6'o20); set_letter("r", 6'o23);
        set_letter("s", 6'o11); set_letter("t", 6'o24); set_letter("u", 6'o53);
        set_letter("v", 6'o04); set_letter("w", 6'o21); set_letter("x", 6'o02);
        set_letter("y", 6'o54); set_letter("z", 6'o01);
        set_key("0", 1'b0, 6'o40); set_key("1", 1'b0, 6'o30); set_key("2", 1'b0, 6'o31);
        set_key("3", 1'b0, 6'o32); set_key("4", 1'b0, 6'o33); set_key("5", 1'b0, 6'o34);
        set_key("6", 1'b0, 6'o44); set_key("7", 1'b0, 6'o43); set_key("8", 1'b0, 6'o42);
        set_key("9", 1'b0, 6'o41);
        set_key(8'h0D, 1'b0, 6'o60); set_key(8'h0A, 1'b0, 6'o60);
        set_key(8'h08, 1'b1, 6'o40); set_key(8'h7F, 1'b1, 6'o40);
        set_key(" ", 1'b0, 6'o70); set_key(".", 1'b0, 6'o71);
        set_key("!", 1'b1, 6'o30); set_key("@", 1'b1, 6'o31); set_key("#", 1'b1, 6'o32);
        set_key("$", 1'b1, 6'o33); set_key("%", 1'b1, 6'o34); set_key("^", 1'b1, 6'o44);
        set_key("&", 1'b1, 6'o43); set_key(8'h22, 1'b1, 6'o50); set_key(",", 1'b1, 6'o71);
        set_key("-", 1'b1, 6'o63); set_key("+", 1'b1, 6'o62); set_key("=", 1'b1, 6'o61);
        set_key(";", 1'b1, 6'o02); set_key(":", 1'b1, 6'o01); set_key("/", 1'b1, 6'o04);
        set_key("<", 1'b1, 6'o23); set_key(">", 1'b1, 6'o24); set_key("(", 1'b1, 6'o41);
        set_key(")", 1'b1, 6'o40); set_key("*", 1'b1, 6'o72);
        // up, down, right, left
        cursor_map[0] = {2'b11, 6'o43};
        cursor_map[1] = {2'b11, 6'o44};
        cursor_map[2] = {2'b11, 6'o42};
        cursor_map[3] = {2'b11, 6'o34};
    endfunction

    function automatic logic [3:0] dec_sat(input logic [3:0] v);
        return (v == 4'd0) ? v : v - 4'd1;
    endfunction

    function automatic void clear_matrix();
        for (int i = 0; i < 8; i++)
            kmat[i] = '0;
    endfunction

    function automatic void strike_key(input logic [7:0] code);
        clear_matrix();
        kmat[code[5:3]][code[2:0]] = 1'b1;
        if (code[6])
            kmat[0][0] = 1'b1;
        hold_gap_left = hold_cfg;
        kb_mode = KB_HOLD;
    endfunction

    function automatic result_t translate_item(input item_t it);
        result_t    r;
        logic [4:0] hit;
        logic       expired;
        r.command     = CMD_NONE;
        r.took_follow = 1'b0;
        r.read_data   = READ_IDLE;
        hit = '0;
        if (it.operation) begin
            for (int i = 0; i < 8; i++)
                if (!it.row_select[i])
                    hit = hit | kmat[i];
            r.read_data = ~{3'b000, hit};
        end else begin
            case (kb_mode)
                KB_ESC:
                begin
                    if (it.char_valid && it.char_code == CHAR_LBRACK) begin
                        kb_mode  = KB_CSI;
                        esc_left = esc_cfg;
                    end else if (it.char_valid && it.char_code == CHAR_UPPER_O) begin
                        r.took_follow = it.follow_valid;
                        if (it.follow_valid && it.follow_code == CHAR_UPPER_P)
                            r.command = CMD_OVERLAY;
                        kb_mode = KB_IDLE;
                    end else if (it.char_valid) begin
                        kb_mode = KB_IDLE;
                    end else begin
                        expired  = (esc_left <= 4'd1);
                        esc_left = dec_sat(esc_left);
                        if (expired)
                            kb_mode = KB_IDLE;
                    end
                end
                KB_CSI:
                begin
                    if (!it.char_valid) begin
                        expired  = (esc_left <= 4'd1);
                        esc_left = dec_sat(esc_left);
                        if (expired)
                            kb_mode = KB_IDLE;
                    end else if (it.char_code >= CHAR_UPPER_A && it.char_code <= CHAR_UPPER_D) begin
                        strike_key(cursor_map[it.char_code[1:0] - 2'd1]);
                    end else begin
                        kb_mode = KB_IDLE;
                    end
                end
                KB_HOLD:
                begin
                    expired       = (hold_gap_left <= 4'd1);
                    hold_gap_left = dec_sat(hold_gap_left);
                    if (expired) begin
                        clear_matrix();
                        hold_gap_left = gap_cfg;
                        kb_mode       = KB_GAP;
                    end
                end
                KB_GAP:
                begin
                    expired       = (hold_gap_left <= 4'd1);
                    hold_gap_left = dec_sat(hold_gap_left);
                    if (expired)
                        kb_mode = KB_IDLE;
                end
                default:
                begin
                    kb_mode = KB_IDLE;
                    if (it.char_valid && !it.char_code[7]) begin
                        if (it.char_code == CHAR_EOT)
                            r.command = CMD_DUMP;
                        else if (it.char_code == CHAR_DC2)
                            r.command = CMD_LAUNCH;
                        else if (it.char_code == CHAR_FF)
                            r.command = CMD_LOAD;
                        else if (it.char_code == CHAR_SI)
                            r.command = CMD_OVERLAY;
                        else if (it.char_code == CHAR_ESC) begin
                            kb_mode  = KB_ESC;
                            esc_left = esc_cfg;
                        end else if (key_map[it.char_code[6:0]][7])
                            strike_key(key_map[it.char_code[6:0]]);
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic item_t tick(input logic cv, input logic [7:0] ch,
                                   input logic fv, input logic [7:0] fc);
        item_t it;
        it.operation    = 1'b0;
        it.char_valid   = cv;
        it.char_code    = ch;
        it.follow_valid = fv;
        it.follow_code  = fc;
        it.row_select   = 8'hFF;
        return it;
    endfunction

    function automatic item_t port_read(input logic [7:0] sel);
        item_t it;
        it = '0;
        it.operation  = 1'b1;
        it.row_select = sel;
        return it;
    endfunction

    function automatic dir_row_t row(input item_t it, input logic typed, input result_t res);
        dir_row_t d;
        d.it    = it;
        d.typed = typed;
        d.res   = res;
        return d;
    endfunction

    function automatic logic [7:0] control_byte();
        case ($urandom_range(0, 3))
            0: return CHAR_EOT;
            1: return CHAR_DC2;
            2: return CHAR_FF;
            default: return CHAR_SI;
        endcase
    endfunction

    // steered by the predicted mode so that escape sequences get finished
    function automatic item_t pick_item();
        item_t it;
        int    roll;
        it.operation    = 1'b0;
        it.char_valid   = 1'b1;
        it.char_code    = 8'($urandom);
        it.follow_valid = 1'($urandom);
        it.follow_code  = 8'($urandom);
        it.row_select   = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            it.operation = 1'b1;
            if ($urandom_range(0, 1) == 0)
                it.row_select = ~(8'h01 << $urandom_range(0, 7));
            return it;
        end
        if (roll < 18) begin
            it.char_valid = 1'($urandom);
            return it;
        end
        roll = $urandom_range(0, 99);
        case (kb_mode)
            KB_IDLE:
            begin
                if (roll < 45) begin
                    do
                        it.char_code = 8'($urandom_range(0, 127));
                    while (!key_map[it.char_code[6:0]][7]);
                end else if (roll < 55)
                    it.char_code = control_byte();
                else if (roll < 75)
                    it.char_code = CHAR_ESC;
                else if (roll < 85)
                    it.char_code[7] = 1'b1;
                else if (roll < 92)
                    it.char_valid = 1'b0;
                else
                    it.char_code = 8'($urandom_range(0, 127));
            end
            KB_ESC:
            begin
                if (roll < 35)
                    it.char_code = CHAR_LBRACK;
                else if (roll < 65) begin
                    it.char_code = CHAR_UPPER_O;
                    if ($urandom_range(0, 1) == 0)
                        it.follow_code = CHAR_UPPER_P;
                end else if (roll < 85)
                    it.char_valid = 1'b0;
            end
            KB_CSI:
            begin
                if (roll < 50)
                    it.char_code = CHAR_UPPER_A + 8'($urandom_range(0, 3));
                else if (roll < 75)
                    it.char_valid = 1'b0;
            end
            default:
                it.char_valid = 1'($urandom);
        endcase
        return it;
    endfunction

    task automatic send_item(input item_t it, input logic typed, input result_t res);
        result_t predicted;
        s_tdata  <= {6'd0, it.row_select, it.follow_code, it.follow_valid,
                     it.char_code, it.char_valid};
        s_tuser  <= it.operation;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = translate_item(it);
        expected_results.push_back(typed ? res : predicted);
    endtask

    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] hold_v, input logic [3:0] gap_v,
                              input logic [3:0] esc_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HOLD_FRAMES;
        cfg_data  <= hold_v;
        @(posedge clk);
        hold_cfg = hold_v;
        cfg_index <= REG_GAP_FRAMES;
        cfg_data  <= gap_v;
        @(posedge clk);
        gap_cfg = gap_v;
        cfg_index <= REG_ESCAPE_FRAMES;
        cfg_data  <= esc_v;
        @(posedge clk);
        esc_cfg = esc_v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: density changes per segment, long hold-off on request
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            stall_left   = HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (seg_left <= 0) begin
                stall_density = $urandom_range(0, 3);
                seg_left      = $urandom_range(20, 80);
            end
            seg_left--;
            m_tready <= (stall_density == 0) || ($urandom_range(0, 3) >= stall_density);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.command     = m_tdata[2:0];
            got.took_follow = m_tdata[3];
            got.read_data   = m_tdata[11:4];
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: command %0d took %0d data %h",
                             got.command, got.took_follow, got.read_data);
            end else begin
                want = expected_results.pop_front();
                if (got.command != want.command || got.took_follow != want.took_follow ||
                    got.read_data != want.read_data) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: command %0d/%0d took %0d/%0d data %h/%h (exp/act)",
                                 want.command, got.command, want.took_follow,
                                 got.took_follow, want.read_data, got.read_data);
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [3:0] cfg_plan [6][3];
        build_key_maps();
        clear_matrix();
        kb_mode       = KB_IDLE;
        hold_gap_left = '0;
        esc_left      = '0;
        hold_cfg      = HOLD_FRAMES_RST;
        gap_cfg       = GAP_FRAMES_RST;
        esc_cfg       = ESCAPE_FRAMES_RST;
        cfg_plan = '{'{4'd1, 4'd1, 4'd1}, '{4'd15, 4'd15, 4'd15}, '{4'd1, 4'd15, 4'd2},
                     '{4'd15, 4'd1, 4'd15}, '{4'd2, 4'd3, 4'd4}, '{4'd3, 4'd2, 4'd5}};
        for (int p = 4; p < 6; p++)
            for (int k = 0; k < 3; k++)
                cfg_plan[p][k] = 4'($urandom_range(1, 15));

        dir_tab.push_back(row(port_read(8'h00), 1'b1, {CMD_NONE, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b0, 8'h00, 1'b1, 8'hFF), 1'b1, {CMD_NONE, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, CHAR_EOT, 1'b0, 8'h00), 1'b1, {CMD_DUMP, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, CHAR_DC2, 1'b0, 8'h00), 1'b1, {CMD_LAUNCH, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, CHAR_FF, 1'b0, 8'h00), 1'b1, {CMD_LOAD, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, CHAR_SI, 1'b0, 8'h00), 1'b1, {CMD_OVERLAY, 1'b0, READ_IDLE}));
        // high bytes and an unmapped byte are dropped in idle
        dir_tab.push_back(row(tick(1'b1, 8'hFF, 1'b1, CHAR_UPPER_P), 1'b1,
                              {CMD_NONE, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, 8'h80, 1'b0, 8'h00), 1'b1, {CMD_NONE, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, 8'h00, 1'b0, 8'h00), 1'b1, {CMD_NONE, 1'b0, READ_IDLE}));
        // ESC O P, ESC O without a second byte, ESC O followed by another byte
        dir_tab.push_back(row(tick(1'b1, CHAR_ESC, 1'b0, 8'h00), 1'b1, {CMD_NONE, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, CHAR_UPPER_O, 1'b1, CHAR_UPPER_P), 1'b1,
                              {CMD_OVERLAY, 1'b1, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, CHAR_ESC, 1'b0, 8'h00), 1'b0, '0));
        dir_tab.push_back(row(tick(1'b1, CHAR_UPPER_O, 1'b0, CHAR_UPPER_P), 1'b1,
                              {CMD_NONE, 1'b0, READ_IDLE}));
        dir_tab.push_back(row(tick(1'b1, CHAR_ESC, 1'b0, 8'h00), 1'b0, '0));
        dir_tab.push_back(row(tick(1'b1, CHAR_UPPER_O, 1'b1, "Q"), 1'b1,
                              {CMD_NONE, 1'b1, READ_IDLE}));
        // other byte after ESC, bad final in CSI
        dir_tab.push_back(row(tick(1'b1, CHAR_ESC, 1'b0, 8'h00), 1'b0, '0));
        dir_tab.push_back(row(tick(1'b1, "x", 1'b0, 8'h00), 1'b0, '0));
        dir_tab.push_back(row(tick(1'b1, CHAR_ESC, 1'b0, 8'h00), 1'b0, '0));
        dir_tab.push_back(row(tick(1'b1, CHAR_LBRACK, 1'b0, 8'h00), 1'b0, '0));
        dir_tab.push_back(row(tick(1'b1, "Z", 1'b0, 8'h00), 1'b0, '0));
        // shifted key, then reads and a byte that hold ignores
        dir_tab.push_back(row(tick(1'b1, 8'h7F, 1'b0, 8'h00), 1'b0, '0));
        dir_tab.push_back(row(port_read(8'hEF), 1'b0, '0));
        dir_tab.push_back(row(port_read(8'hFE), 1'b0, '0));
        dir_tab.push_back(row(port_read(8'h00), 1'b0, '0));
        dir_tab.push_back(row(tick(1'b1, "a", 1'b0, 8'h00), 1'b0, '0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
            pace();
        end
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(pick_item(), 1'b0, '0);
            pace();
        end

        for (int p = 0; p < 6; p++) begin
            drain();
            set_config(cfg_plan[p][0], cfg_plan[p][1], cfg_plan[p][2]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((p == 1 && n == 5) || (p == 3 && n == 60)) begin
                    holdoff_req++;
                    burst_left = 60;
                end
                if (p == 4 && n == 50) begin
                    drain();
                    @(posedge clk);
                end
                send_item(pick_item(), 1'b0, '0);
                pace();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
